/* rtl/core/lru_page_replacement_unit_macros.svh */
// Assertion macros for the LRU page replacement unit checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define LRUPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrupr same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define LRUPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrupr next-cycle check failed");

`endif

/* rtl/core/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement unit.
// No dependencies; imported by the cell, the top level and the checker.
package lrupr_pkg;

   localparam int PAGE_FIELD_W = 16;
   localparam int FAULT_W      = 32;
   localparam int CSR_W        = 5;

   localparam logic [CSR_W-1:0] FRAME_COUNT_RESET = 5'd4;

   // per-transfer control broadcast to every cell of the recency stack
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic hit;      // page found somewhere in the stack
      logic full;     // occupancy has reached the active frame count
      logic clear;    // last reference: drop all entries after this one
   } lrupr_ctl_type;

endpackage

/* rtl/core/lru_page_replacement_unit.sv */
// LRU page replacement unit: the result is registered, valid in the cycle after a transfer.
// One reference per cycle unless stalled; all cells compare and shift together.
// Recency is kept as a chain of FRAMES cells ordered most recent first.
// Synchronous active-high reset empties all frames, zeroes the fault count and
// sets the frame count register to 4. Page storage itself is not reset.
// Depends on lrupr_pkg and lrupr_cell.
module lru_page_replacement_unit
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_wr_en,
   input  logic [CSR_W-1:0]        csr_wr_data,
   // reference stream
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PAGE_FIELD_W-1:0] req_page_number,
   input  logic                    req_last_ref,
   // results
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic                    rsp_evicted_valid,
   output logic [PAGE_FIELD_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]      rsp_fault_total,
   output logic                    rsp_string_done
);

   // stored page width: the port is 16 bits, PAGE_BITS may narrow it further
   localparam int SW    = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [6:0] FRAMES_C = 7'(FRAMES);

   // ---------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------
   logic [CSR_W-1:0] frame_count_ff, frame_count_in;

   assign frame_count_in = csr_wr_en ? csr_wr_data : frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   // active frames minus one, clamped to 1..FRAMES
   logic [6:0] fc_ext;
   logic [6:0] active_m1;

   always_comb begin
      fc_ext = 7'(frame_count_ff);
      if (fc_ext == 7'd0) begin
         active_m1 = 7'd0;
      end else if (fc_ext > FRAMES_C) begin
         active_m1 = FRAMES_C - 7'd1;
      end else begin
         active_m1 = fc_ext - 7'd1;
      end
   end

   // ---------------------------------------------------------------
   // handshake: the output register frees the input side whenever it
   // is empty or its result is being transferred this cycle
   // ---------------------------------------------------------------
   logic accept;

   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // recency stack: cell 0 is most recent, valid entries form a prefix
   // ---------------------------------------------------------------
   logic [SW-1:0]     req_page;
   logic [SW-1:0]     cell_page [FRAMES];
   logic [FRAMES-1:0] cell_valid;
   logic [FRAMES:0]   valid_ext;
   logic [FRAMES:0]   tail;
   lrupr_ctl_type     ctl;
   logic              hit;
   logic              full;

   assign req_page    = req_page_number[SW-1:0];
   assign tail[FRAMES] = 1'b0;
   assign hit         = tail[0];
   assign valid_ext   = {1'b0, cell_valid};

   // occupancy reaches the active count exactly when that cell is valid;
   // a lowered count leaves deeper cells valid, which still reads as full
   assign full = cell_valid[active_m1[IDX_W-1:0]];

   assign ctl.accept = accept;
   assign ctl.hit    = hit;
   assign ctl.full   = full;
   assign ctl.clear  = accept && req_last_ref;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      logic [SW-1:0] up_page;
      logic          up_valid;

      if (i == 0) begin : g_head
         // the head cell loads the referenced page on every transfer
         assign up_page  = req_page;
         assign up_valid = 1'b1;
      end else begin : g_body
         assign up_page  = cell_page[i-1];
         assign up_valid = cell_valid[i-1];
      end

      lrupr_cell #(
         .PAGE_W (SW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .req_page  (req_page),
         .up_page   (up_page),
         .up_valid  (up_valid),
         .tail_in   (tail[i+1]),
         .tail_out  (tail[i]),
         .page_out  (cell_page[i]),
         .valid_out (cell_valid[i])
      );
   end

   // ---------------------------------------------------------------
   // victim: the deepest valid cell (least recent)
   // ---------------------------------------------------------------
   logic [SW-1:0] victim_page;
   logic          evict;

   always_comb begin
      victim_page = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (valid_ext[i] && !valid_ext[i+1]) begin
            victim_page = victim_page | cell_page[i];
         end
      end
   end

   assign evict = !hit && full;

   // ---------------------------------------------------------------
   // fault counter, saturating, cleared after the last reference
   // ---------------------------------------------------------------
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic [FAULT_W-1:0] fault_next;

   assign fault_next = (!hit && !(&fault_ff)) ? fault_ff + 1'b1 : fault_ff;

   always_comb begin
      fault_in = fault_ff;
      if (accept) begin
         fault_in = req_last_ref ? '0 : fault_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= '0;
      end else begin
         fault_ff <= fault_in;
      end
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    hit_ff;
   logic                    evict_ff;
   logic [PAGE_FIELD_W-1:0] evict_page_ff;
   logic [FAULT_W-1:0]      total_ff;
   logic                    done_ff;

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff        <= hit;
         evict_ff      <= evict;
         evict_page_ff <= evict ? PAGE_FIELD_W'(victim_page) : '0;
         total_ff      <= fault_next;
         done_ff       <= req_last_ref;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = evict_ff;
   assign rsp_evicted_page  = evict_page_ff;
   assign rsp_fault_total   = total_ff;
   assign rsp_string_done   = done_ff;

endmodule

/* rtl/core/lrupr_cell.sv */
// One entry of the LRU recency stack: a page and its valid bit.
// Depends on lrupr_pkg; instantiated in a chain by lru_page_replacement_unit.
module lrupr_cell
   import lrupr_pkg::*;
#(
   parameter int PAGE_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  lrupr_ctl_type     ctl,
   input  logic [PAGE_W-1:0] req_page,
   input  logic [PAGE_W-1:0] up_page,
   input  logic              up_valid,
   input  logic              tail_in,
   output logic              tail_out,
   output logic [PAGE_W-1:0] page_out,
   output logic              valid_out
);

   logic [PAGE_W-1:0] page_ff, page_in;
   logic              valid_ff, valid_in;
   logic              match;
   logic              take;

   assign match    = valid_ff && (page_ff == req_page);
   // true when the hit lies at this entry or deeper in the stack
   assign tail_out = tail_in | match;

   // hit: entries above the hit move down one
   // miss with room: every valid entry moves down, the first free one fills
   // miss when full: valid entries move down, the deepest one falls out
   always_comb begin
      if (ctl.hit) begin
         take = ctl.accept && tail_out;
      end else if (ctl.full) begin
         take = ctl.accept && valid_ff;
      end else begin
         take = ctl.accept && up_valid;
      end
      page_in  = take ? up_page : page_ff;
      valid_in = ctl.clear ? 1'b0 : (take ? up_valid : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page_out  = page_ff;
   assign valid_out = valid_ff;

endmodule

/* rtl/core/lrupr_checker.sv */
// Port-level checks for the LRU page replacement unit, bound to its top level.
// Depends on lrupr_pkg and lru_page_replacement_unit_macros.svh.
`include "lru_page_replacement_unit_macros.svh"

module lrupr_checker
   import lrupr_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_hit,
   input logic                    rsp_evicted_valid,
   input logic [PAGE_FIELD_W-1:0] rsp_evicted_page,
   input logic [FAULT_W-1:0]      rsp_fault_total
);

   // a hit never replaces a page
   `LRUPR_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid)

   // without a replacement the victim field reads zero
   `LRUPR_ASSERT_IMP(a_evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)

   // a fault is counted in its own result
   `LRUPR_ASSERT_IMP(a_fault_counted, clock, reset, rsp_valid && !rsp_hit, rsp_fault_total != '0)

   // a result is valid in the cycle after an input transfer
   `LRUPR_ASSERT_NXT(a_latency, clock, reset, req_valid && !req_stall, rsp_valid)

   // a stalled result holds
   `LRUPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fault_total))

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (.*);
